FILE: rtl/sapdc_pkg.sv
// Package for the sector-aware patch diff chunker.
// Holds geometry constants, derived widths, record kinds and the FSM type.
// No dependencies.
package sapdc_pkg;

	localparam int CHUNK_MAX     = 32;
	localparam int SECTOR_SIZE   = 2352;
	localparam int SECTOR_DATA   = 2048;
	localparam int SECTOR_HEADER = 24;

	localparam int ADDR_W = (CHUNK_MAX > 1) ? $clog2(CHUNK_MAX) : 1;
	localparam int SEC_W  = $clog2(SECTOR_SIZE);
	localparam int FILL_W = 6;
	localparam int POS_W  = 32;
	localparam int ENTRY_W = 16;

	localparam logic [SEC_W-1:0] SEC_END_TH  = SEC_W'(SECTOR_DATA + SECTOR_HEADER - 1);
	localparam logic [SEC_W:0]   SEC_SIZE_C  = (SEC_W + 1)'(SECTOR_SIZE);
	localparam logic [SEC_W:0]   SEC_SKIP    = (SEC_W + 1)'(SECTOR_SIZE - SECTOR_DATA + 1);
	localparam logic [POS_W:0]   POS_SKIP    = (POS_W + 1)'(SECTOR_SIZE - SECTOR_DATA + 1);
	localparam logic [FILL_W-1:0] PART_FULL  = FILL_W'(CHUNK_MAX);

	// sector offset of a position: 2352 = 147 * 16, low 4 bits pass through,
	// the upper part is reduced mod 147 by a reciprocal multiply
	localparam int SEC_LO_W = 4;
	localparam int SEC_HI   = SECTOR_SIZE >> SEC_LO_W;
	localparam int HI_W     = POS_W - SEC_LO_W;
	localparam int RECIP_SH = HI_W + 8;
	localparam int RECIP_W  = 29;
	localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((64'd1 << RECIP_SH) / SEC_HI);
	localparam int PROD_W   = HI_W + RECIP_W;
	localparam int QUO_W    = PROD_W - RECIP_SH;
	localparam int HREM_W   = SEC_W - SEC_LO_W + 1;
	localparam logic [HREM_W-1:0] SEC_HI_C = HREM_W'(SEC_HI);

	localparam logic KIND_HDR  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HDR,
		ST_DATA
	} state_t;

endpackage

FILE: rtl/sapdc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds its value until the next read enable. No dependencies.
module sapdc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/sector_aware_patch_diff_chunker_unit.sv
// Top level of the sector-aware patch diff chunker.
// Uses sapdc_pkg for constants and types, sapdc_ram for the chunk store.
//
// Usage:
//   s_* stream: one transaction per byte pair, tdata = {old_byte, new_byte},
//   tlast marks the final byte of the replacement data.
//   m_* stream: header records (tuser = 0, position and size) followed by
//   the chunk's byte pairs (tuser = 1); tlast on the final pair of a chunk.
//   APB register 0 (address 0) is start_offset; writing it restarts the run.
//   Pairs are stored in a 32-entry RAM. A pair that does not close a chunk,
//   or closes one with no differing byte, emits no record. A closing pair of
//   a differing chunk is followed by its header, then one RAM read per data
//   record, streamed one record per cycle while m_tready is high.
//   The in-sector offset is kept incrementally; after a start_offset write
//   or a 32-bit position wrap it is rebuilt by a reciprocal multiply and
//   one compare and subtract, during which s_tready is low.
//   Reset: start_offset and position 0, empty chunk, no rebuild pending.
//   A stalled receiver holds the output register; s_tready is low while a
//   chunk is being emitted, but the next pair is taken while the final
//   record of a chunk waits on m_tready.
module sector_aware_patch_diff_chunker_unit (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: new_byte [7:0], old_byte [15:8]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        s_tlast,
	// m_tdata: iso_position [31:0], record_size [37:32], new_byte_out [45:38],
	//          old_byte_out [53:46], zero [55:54]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,
	// m_tuser: record_kind [0]
	output logic [0:0]  m_tuser,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sapdc_pkg::*;

	state_t state_q, state_d;

	logic [POS_W-1:0]  start_q;
	logic [POS_W-1:0]  pos_q;
	logic [SEC_W-1:0]  sec_q;
	logic [FILL_W-1:0] fill_q;
	logic              diff_q;

	logic [POS_W-1:0]  chunk_pos_q;
	logic [FILL_W-1:0] chunk_len_q;
	logic [FILL_W-1:0] issue_idx_q;
	logic              avail_q;

	logic              mod_busy_q;
	logic              mod_step_q;
	logic [POS_W-1:0]  mod_val_q;
	logic [QUO_W-1:0]  mod_quo_q;
	logic [HREM_W-1:0] mod_hrem;
	logic [HREM_W-1:0] mod_hfix;
	logic [SEC_W-1:0]  mod_sec;

	logic              out_valid_q;
	logic              out_kind_q;
	logic [POS_W-1:0]  out_pos_q;
	logic [FILL_W-1:0] out_size_q;
	logic [7:0]        out_nb_q;
	logic [7:0]        out_ob_q;
	logic              out_last_q;
	logic              out_free;

	logic              cfg_wr;
	logic              acc;
	logic [7:0]        in_nb;
	logic [7:0]        in_ob;
	logic              sector_end;
	logic [FILL_W-1:0] fill_new;
	logic              diff_new;
	logic              close;
	logic [POS_W:0]    pos_next;
	logic [SEC_W:0]    sec_sum;
	logic [SEC_W-1:0]  sec_next;

	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic              ld_hdr;
	logic              ld_data;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? start_q : 32'd0;

	assign s_tready = (state_q == ST_IDLE) && !mod_busy_q;
	assign acc      = s_tvalid && s_tready;
	assign in_nb    = s_tdata[7:0];
	assign in_ob    = s_tdata[15:8];

	assign sector_end = (sec_q >= SEC_END_TH);
	assign fill_new   = fill_q + FILL_W'(1);
	assign diff_new   = diff_q || (in_nb != in_ob);
	assign close      = sector_end || (fill_new == PART_FULL) || s_tlast;
	assign pos_next   = {1'b0, pos_q} + (sector_end ? POS_SKIP : (POS_W + 1)'(1));
	assign sec_sum    = {1'b0, sec_q} + (sector_end ? SEC_SKIP : (SEC_W + 1)'(1));
	assign sec_next   = (sec_sum >= SEC_SIZE_C) ? SEC_W'(sec_sum - SEC_SIZE_C)
	                                            : sec_sum[SEC_W-1:0];

	// quotient may be one low, so the upper remainder is below twice 147
	assign mod_hrem = mod_val_q[SEC_LO_W+HREM_W-1:SEC_LO_W] - HREM_W'(mod_quo_q * SEC_HI);
	assign mod_hfix = (mod_hrem >= SEC_HI_C) ? mod_hrem - SEC_HI_C : mod_hrem;
	assign mod_sec  = {mod_hfix[SEC_W-SEC_LO_W-1:0], mod_val_q[SEC_LO_W-1:0]};

	assign out_free = !out_valid_q || m_tready;
	assign ram_we   = acc;

	sapdc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CHUNK_MAX)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_q[ADDR_W-1:0]),
		.wdata({in_nb, in_ob}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		ram_raddr = issue_idx_q[ADDR_W-1:0];
		ld_hdr    = 1'b0;
		ld_data   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc && close && diff_new) begin
					state_d = ST_HDR;
				end
			end
			ST_HDR: begin
				if (out_free) begin
					ld_hdr    = 1'b1;
					ram_re    = 1'b1;
					ram_raddr = '0;
					state_d   = ST_DATA;
				end
			end
			ST_DATA: begin
				if (avail_q && out_free) begin
					ld_data = 1'b1;
					if (issue_idx_q < chunk_len_q) begin
						ram_re = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= '0;
			pos_q      <= '0;
			sec_q      <= '0;
			fill_q     <= '0;
			diff_q     <= 1'b0;
			mod_busy_q <= 1'b0;
			mod_step_q <= 1'b0;
		end else if (cfg_wr) begin
			start_q    <= pwdata;
			pos_q      <= pwdata;
			fill_q     <= '0;
			diff_q     <= 1'b0;
			mod_busy_q <= 1'b1;
			mod_step_q <= 1'b0;
		end else if (acc) begin
			pos_q <= pos_next[POS_W-1:0];
			if (close) begin
				fill_q <= '0;
				diff_q <= 1'b0;
			end else begin
				fill_q <= fill_new;
				diff_q <= diff_new;
			end
			if (pos_next[POS_W]) begin
				mod_busy_q <= 1'b1;
				mod_step_q <= 1'b0;
			end else begin
				sec_q <= sec_next;
			end
		end else if (mod_busy_q) begin
			if (!mod_step_q) begin
				mod_step_q <= 1'b1;
			end else begin
				mod_busy_q <= 1'b0;
				sec_q      <= mod_sec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_wr) begin
			mod_val_q <= pwdata;
		end else if (acc && pos_next[POS_W]) begin
			mod_val_q <= pos_next[POS_W-1:0];
		end
		if (mod_busy_q && !mod_step_q) begin
			mod_quo_q <= QUO_W'((PROD_W'(mod_val_q[POS_W-1:SEC_LO_W]) * PROD_W'(RECIP_M))
				>> RECIP_SH);
		end
		if (acc && close) begin
			chunk_pos_q <= pos_q - POS_W'(fill_q);
			chunk_len_q <= fill_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avail_q     <= 1'b0;
			issue_idx_q <= '0;
		end else if (ld_hdr) begin
			avail_q     <= 1'b1;
			issue_idx_q <= FILL_W'(1);
		end else if (ld_data) begin
			if (ram_re) begin
				issue_idx_q <= issue_idx_q + FILL_W'(1);
			end else begin
				avail_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_hdr || ld_data) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_hdr) begin
			out_kind_q <= KIND_HDR;
			out_pos_q  <= chunk_pos_q;
			out_size_q <= chunk_len_q;
			out_nb_q   <= '0;
			out_ob_q   <= '0;
			out_last_q <= 1'b0;
		end else if (ld_data) begin
			out_kind_q <= KIND_DATA;
			out_pos_q  <= '0;
			out_size_q <= '0;
			out_nb_q   <= ram_rdata[15:8];
			out_ob_q   <= ram_rdata[7:0];
			out_last_q <= (issue_idx_q == chunk_len_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'b00, out_ob_q, out_nb_q, out_size_q, out_pos_q};

	// the store is never written while a chunk is being read out
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("chunk store written during readout");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DATA) |-> (issue_idx_q <= chunk_len_q))
		else $error("read index beyond chunk length");

	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser == KIND_DATA))
		else $error("tlast on a header record");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < PART_FULL)
		else $error("chunk fill count reached part size");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for sector_aware_patch_diff_chunker_unit.
// Streams byte pairs, writes start_offset over APB and checks every header and data record
// against a predictor of the chunker kept in this file. Needs sapdc_pkg and the RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sapdc_pkg::*;

	localparam logic [2:0] ADDR_START_OFFSET = 3'd0;
	localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 2000;
	localparam int MAX_PRINTS    = 30;

	typedef enum {ROW_PAIR, ROW_WRITE} row_kind_t;
	typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	typedef struct {
		logic        kind;
		logic [31:0] iso_pos;
		logic [5:0]  size;
		logic [7:0]  nb;
		logic [7:0]  ob;
		logic        last_rec;
	} patch_rec_t;

	// hsize != 0 on a pair row types in the header that row must produce
	typedef struct {
		row_kind_t   kind;
		logic [2:0]  addr;
		logic [31:0] value;
		logic [7:0]  nb;
		logic [7:0]  ob;
		logic        last;
		logic [31:0] hpos;
		logic [5:0]  hsize;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sector_aware_patch_diff_chunker_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// chunker model state
	logic [31:0] offset_reg;
	logic [31:0] img_pos;
	int unsigned chunk_fill;
	bit          chunk_dirty;
	logic [15:0] chunk_pairs [CHUNK_MAX];
	patch_rec_t  due_recs [$];

	int mismatch_cnt;
	int pairs_sent;
	int recs_checked;
	int hdrs_checked;
	int offsets_used;
	int idle_cycles;

	bit       steady_send;
	int       burst_left;
	rx_mode_t rx_mode;
	int       holds_asked;
	int       holds_done;
	int       hold_cnt;
	int       rx_tick;
	patch_rec_t mon_rec;

	task automatic flag_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_PRINTS)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	task automatic chunk_predict(input logic [7:0] nb, input logic [7:0] ob, input logic last);
		int unsigned in_sec;
		bit          sec_end;
		logic [31:0] chunk_start;
		patch_rec_t  r;
		if (chunk_fill < CHUNK_MAX)
			chunk_pairs[chunk_fill] = {nb, ob};
		chunk_fill = (chunk_fill + 1) & 63;
		if (nb != ob)
			chunk_dirty = 1'b1;
		in_sec = img_pos % 32'(SECTOR_SIZE);
		sec_end = in_sec >= 32'(SECTOR_DATA + SECTOR_HEADER - 1);
		if (sec_end || chunk_fill >= CHUNK_MAX || last) begin
			if (chunk_dirty) begin
				chunk_start = img_pos - chunk_fill + 32'd1;
				r = '{KIND_HDR, chunk_start, 6'(chunk_fill), 8'h00, 8'h00, 1'b0};
				due_recs.push_back(r);
				for (int i = 0; i < chunk_fill && i < CHUNK_MAX; i++) begin
					r = '{KIND_DATA, 32'h0, 6'h0, chunk_pairs[i][15:8], chunk_pairs[i][7:0],
						(i + 1 == chunk_fill)};
					due_recs.push_back(r);
				end
			end
			chunk_fill = 0;
			chunk_dirty = 1'b0;
		end
		img_pos = img_pos + 32'd1;
		if (sec_end)
			img_pos = img_pos + 32'(SECTOR_SIZE - SECTOR_DATA);
	endtask

	task automatic send_pair(input logic [7:0] nb, input logic [7:0] ob, input logic last,
			input logic [31:0] hpos, input logic [5:0] hsize);
		int gap;
		int n_before;
		s_tvalid <= 1'b1;
		s_tdata  <= {ob, nb};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		n_before = due_recs.size();
		chunk_predict(nb, ob, last);
		pairs_sent++;
		if (hsize != 0) begin
			if (due_recs.size() > n_before) begin
				due_recs[n_before].iso_pos = hpos;
				due_recs[n_before].size = hsize;
			end else begin
				flag_mismatch($sformatf("pair %0d should close a chunk at %h", pairs_sent, hpos));
			end
		end
		gap = 0;
		if (!steady_send) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				gap = $urandom_range(1, 6);
			end else begin
				burst_left--;
			end
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (due_recs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_START_OFFSET) begin
			offset_reg = value;
			img_pos = value;
			chunk_fill = 0;
			chunk_dirty = 1'b0;
			offsets_used++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cfg_check(input logic [31:0] want);
		logic [31:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_START_OFFSET;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== want)
			flag_mismatch($sformatf("start_offset read %h, want %h", got, want));
	endtask

	task automatic run_phase(input logic [31:0] offset, input int n_items, input int diff_pct,
			input int last_pct, input int hold_at, input int drain_at);
		logic [7:0] nb;
		logic [7:0] ob;
		logic       last;
		wait_idle();
		cfg_write(ADDR_START_OFFSET, offset);
		cfg_check(offset_reg);
		for (int i = 0; i < n_items; i++) begin
			if (i == hold_at)
				holds_asked++;
			if (i == drain_at)
				wait_idle();
			nb = 8'($urandom);
			ob = ($urandom_range(0, 99) < diff_pct) ? 8'($urandom) : nb;
			last = $urandom_range(0, 99) < last_pct;
			send_pair(nb, ob, last, 32'h0, 6'h0);
		end
	endtask

	function automatic dir_row_t pair_row(input logic [7:0] nb, input logic [7:0] ob,
			input logic last, input logic [31:0] hpos, input logic [5:0] hsize);
		return '{ROW_PAIR, 3'd0, 32'h0, nb, ob, last, hpos, hsize};
	endfunction

	function automatic dir_row_t wr_row(input logic [2:0] addr, input logic [31:0] value);
		return '{ROW_WRITE, addr, value, 8'h00, 8'h00, 1'b0, 32'h0, 6'h0};
	endfunction

	// receiver: long hold-offs on request, otherwise a mode-driven stall pattern
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else if (holds_asked != holds_done) begin
			holds_done <= holds_done + 1;
			hold_cnt <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN:     m_tready <= 1'b1;
				RX_RANDOM:   m_tready <= $urandom_range(0, 3) != 0;
				RX_PERIODIC: m_tready <= (rx_tick % 7) < 3;
				default:     m_tready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			recs_checked++;
			if (due_recs.size() == 0) begin
				flag_mismatch($sformatf("unexpected record kind %0b tdata %h", m_tuser[0], m_tdata));
			end else begin
				mon_rec = due_recs.pop_front();
				if (mon_rec.kind == KIND_HDR)
					hdrs_checked++;
				if (m_tuser[0] !== mon_rec.kind || m_tdata[31:0] !== mon_rec.iso_pos
						|| m_tdata[37:32] !== mon_rec.size || m_tdata[45:38] !== mon_rec.nb
						|| m_tdata[53:46] !== mon_rec.ob || m_tdata[55:54] !== 2'b00
						|| m_tlast !== mon_rec.last_rec)
					flag_mismatch($sformatf(
						"rec %0d got k%0b pos %h sz %0d %h/%h l%0b, want k%0b pos %h sz %0d %h/%h l%0b",
						recs_checked, m_tuser[0], m_tdata[31:0], m_tdata[37:32], m_tdata[45:38],
						m_tdata[53:46], m_tlast, mon_rec.kind, mon_rec.iso_pos, mon_rec.size,
						mon_rec.nb, mon_rec.ob, mon_rec.last_rec));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles, %0d records pending",
				STALL_LIMIT, due_recs.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		dir_row_t    dir_rows [$];
		logic [31:0] sec_base;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		mismatch_cnt = 0;
		pairs_sent = 0;
		recs_checked = 0;
		hdrs_checked = 0;
		offsets_used = 0;
		idle_cycles = 0;
		steady_send = 1'b0;
		burst_left = 0;
		rx_mode = RX_RANDOM;
		holds_asked = 0;
		holds_done = 0;
		hold_cnt = 0;
		rx_tick = 0;
		offset_reg = '0;
		img_pos = '0;
		chunk_fill = 0;
		chunk_dirty = 1'b0;
		foreach (chunk_pairs[i])
			chunk_pairs[i] = '0;

		// equal pair dropped, then single differing bytes at both extremes
		dir_rows.push_back(pair_row(8'h00, 8'h00, 1'b1, 32'h0, 6'd0));
		dir_rows.push_back(pair_row(8'hff, 8'h00, 1'b1, 32'd1, 6'd1));
		dir_rows.push_back(pair_row(8'h00, 8'hff, 1'b1, 32'd2, 6'd1));
		// chunk closed by the end of a sector's data area, then skip into the next sector
		dir_rows.push_back(wr_row(ADDR_START_OFFSET, 32'd2069));
		dir_rows.push_back(pair_row(8'ha5, 8'ha5, 1'b0, 32'h0, 6'd0));
		dir_rows.push_back(pair_row(8'h5a, 8'h5a, 1'b0, 32'h0, 6'd0));
		dir_rows.push_back(pair_row(8'h12, 8'h34, 1'b0, 32'd2069, 6'd3));
		dir_rows.push_back(pair_row(8'h77, 8'h77, 1'b1, 32'h0, 6'd0));
		// start past the data area: one-byte chunk
		dir_rows.push_back(wr_row(ADDR_START_OFFSET, 32'd2100));
		dir_rows.push_back(pair_row(8'h01, 8'h02, 1'b0, 32'd2100, 6'd1));
		dir_rows.push_back(pair_row(8'h03, 8'h03, 1'b1, 32'h0, 6'd0));
		// chunk spanning the 32-bit position wrap
		dir_rows.push_back(wr_row(ADDR_START_OFFSET, 32'hffff_fffe));
		dir_rows.push_back(pair_row(8'h10, 8'h11, 1'b0, 32'h0, 6'd0));
		dir_rows.push_back(pair_row(8'h20, 8'h20, 1'b0, 32'h0, 6'd0));
		dir_rows.push_back(pair_row(8'h30, 8'h30, 1'b0, 32'h0, 6'd0));
		dir_rows.push_back(pair_row(8'h40, 8'h40, 1'b1, 32'hffff_fffe, 6'd4));
		dir_rows.push_back(wr_row(ADDR_UNMAPPED, 32'h1234_5678));
		dir_rows.push_back(wr_row(ADDR_START_OFFSET, 32'hffff_ffff));
		dir_rows.push_back(pair_row(8'hff, 8'hfe, 1'b1, 32'hffff_ffff, 6'd1));
		// partly filled differing chunk thrown away by an offset write
		dir_rows.push_back(pair_row(8'h55, 8'haa, 1'b0, 32'h0, 6'd0));
		dir_rows.push_back(wr_row(ADDR_START_OFFSET, 32'h0));
		dir_rows.push_back(pair_row(8'h00, 8'h00, 1'b1, 32'h0, 6'd0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cfg_check(32'h0);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				wait_idle();
				cfg_write(dir_rows[i].addr, dir_rows[i].value);
				cfg_check(offset_reg);
			end else begin
				send_pair(dir_rows[i].nb, dir_rows[i].ob, dir_rows[i].last,
					dir_rows[i].hpos, dir_rows[i].hsize);
			end
		end

		sec_base = 32'($urandom_range(0, 1000)) * 32'(SECTOR_SIZE);
		rx_mode = RX_RANDOM;
		run_phase(sec_base + 32'(SECTOR_HEADER) + 32'($urandom_range(0, SECTOR_DATA - 1)),
			24, 30, 6, -1, -1);
		rx_mode = RX_PERIODIC;
		run_phase(sec_base + 32'(SECTOR_DATA + SECTOR_HEADER - 1) - 32'($urandom_range(0, 40)),
			24, 60, 4, -1, 12);
		rx_mode = RX_OPEN;
		steady_send = 1'b1;
		run_phase(32'hffff_ffff - 32'($urandom_range(0, 40)), 24, 50, 10, 3, -1);
		steady_send = 1'b0;
		rx_mode = RX_RANDOM;
		run_phase(32'h0, 24, 3, 3, -1, -1);
		rx_mode = RX_PERIODIC;
		run_phase(32'hffff_ffff, 24, 40, 8, -1, -1);
		rx_mode = RX_OPEN;
		steady_send = 1'b1;
		run_phase(32'($urandom), 24, 20, 5, -1, -1);

		wait_idle();
		$display("Sent %0d byte pairs over %0d start offsets (sector ends, wrap, long stall).",
			pairs_sent, offsets_used);
		$display("Checked %0d records, %0d of them chunk headers; %0d mismatches.",
			recs_checked, hdrs_checked, mismatch_cnt);
		if (mismatch_cnt == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
